// ===== sv/hcs_pkg.sv =====
package hcs_pkg;

  // default widths
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COEF_BITS_DEF   = 24;

  // result format: unsigned Q16.8
  localparam int unsigned RATE_BITS      = 24;
  localparam int unsigned RATE_FRAC_BITS = 8;

  // config channel index width
  localparam int unsigned CFG_IDX_BITS = 3;

  // drive = 10*s + A, permeability ~ drive/(drive+B), A and B scaled to the sample format
  localparam int unsigned DRIVE_A = 5;
  localparam int unsigned DRIVE_B = 300;

  // firing rate scale h
  localparam int unsigned RATE_H      = 50000;
  localparam int unsigned RATE_H_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GAIN       = 3'd0,
    CFG_REPLENISH  = 3'd1,
    CFG_LOSS       = 3'd2,
    CFG_RETURN     = 3'd3,
    CFG_REPROCESS  = 3'd4,
    CFG_REST_FREE  = 3'd5,
    CFG_REST_CLEFT = 3'd6,
    CFG_REST_STORE = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KMUL,
    ST_DINIT,
    ST_DIV,
    ST_MEJECT,
    ST_MREPL,
    ST_MLOSS,
    ST_MREUP,
    ST_MREPRO,
    ST_UPDATE,
    ST_MRATE,
    ST_FINISH
  } state_e;

endpackage

// ===== sv/hcs_if.sv =====
interface hcs_in_if #(
  parameter int unsigned SAMPLE_BITS = hcs_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] membrane_sample;
  logic                          first_of_channel;

  modport source (output valid, membrane_sample, first_of_channel, input ready);
  modport sink   (input valid, membrane_sample, first_of_channel, output ready);
endinterface

interface hcs_out_if;
  logic                           valid;
  logic                           ready;
  logic [hcs_pkg::RATE_BITS-1:0]  firing_rate;

  modport source (output valid, firing_rate, input ready);
  modport sink   (input valid, firing_rate, output ready);
endinterface

interface hcs_cfg_if #(
  parameter int unsigned COEF_BITS = hcs_pkg::COEF_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [hcs_pkg::CFG_IDX_BITS-1:0] index;
  logic [COEF_BITS-1:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/hair_cell_synapse_model_core.sv =====
// Meddis-style inner hair cell synapse, one cochlear channel.
// in_i   : one basilar membrane sample (signed) plus a first-of-channel flag; a set
//          flag reloads free transmitter, cleft and reprocessing store from the
//          resting registers before the sample is applied.
// out_o  : one firing rate per sample, unsigned Q16.8, 50000 times the new cleft.
// cfg_i  : register writes (index, data), always ready; write only while idle.
//          Indexes: gain, replenish, loss, return, reprocess, rest free/cleft/store.
// Timing : after its transfer a sample runs through one product for the
//          permeability numerator, a divider load step, the restoring divider
//          retiring one quotient bit per cycle, six more passes through the shared
//          multiplier, a store update step and a result step that waits while an
//          earlier result is still unread. The next sample is taken only once the
//          block is back in idle.
// Stall  : the result sits in an output register; the block goes idle and takes
//          the next sample while it waits, and holds before overwriting it until
//          the receiver has taken it.
// Reset  : stores clear to zero, coefficients to zero, rest_free to all ones,
//          no result pending.
module hair_cell_synapse_model_core #(
  parameter int unsigned SAMPLE_BITS = hcs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS   = hcs_pkg::COEF_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcs_in_if.sink    in_i,
  hcs_out_if.source out_o,
  hcs_cfg_if.sink   cfg_i
);

  // derived widths
  localparam int unsigned DRV_W  = SAMPLE_BITS + 5;   // signed drive
  localparam int unsigned NUM_W  = SAMPLE_BITS + 3;   // positive drive
  localparam int unsigned DEN_W  = SAMPLE_BITS + 8;   // drive + B
  localparam int unsigned MB_0   = (NUM_W > COEF_BITS + 1) ? NUM_W : COEF_BITS + 1;
  localparam int unsigned MB     = (MB_0 > hcs_pkg::RATE_H_BITS) ? MB_0 : hcs_pkg::RATE_H_BITS;
  localparam int unsigned PROD_W = COEF_BITS + MB;
  localparam int unsigned SUM_W  = COEF_BITS + 3;
  localparam int unsigned CNT_W  = $clog2(COEF_BITS);
  localparam int unsigned RLO    = COEF_BITS - hcs_pkg::RATE_FRAC_BITS;
  localparam int unsigned RHI    = RLO + hcs_pkg::RATE_BITS;

  localparam logic signed [DRV_W-1:0] DriveOfs =
    DRV_W'(hcs_pkg::DRIVE_A) << (SAMPLE_BITS - 1);
  localparam logic [DEN_W-1:0] DenOfs = DEN_W'(hcs_pkg::DRIVE_B) << (SAMPLE_BITS - 1);
  localparam logic [MB-1:0]    RateH  = MB'(hcs_pkg::RATE_H);
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(COEF_BITS - 1);

  // configuration registers
  logic [COEF_BITS-1:0] gain_q, repl_coef_q, loss_coef_q, ret_coef_q, repro_coef_q;
  logic [COEF_BITS-1:0] rest_free_q, rest_cleft_q, rest_store_q;

  // stores
  logic [COEF_BITS-1:0] free_q, cleft_q, store_q;

  // sequencer
  hcs_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;

  // datapath
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [PROD_W-1:0]    prod_q;
  logic [DEN_W-1:0]     den_q, rem_q;
  logic [COEF_BITS-1:0] lo_q;       // dividend low bits shifted out, quotient shifted in
  logic [COEF_BITS-1:0] eject_q, repl_q, loss_q, reup_q;
  logic                 out_valid_q;
  logic [hcs_pkg::RATE_BITS-1:0] rate_q;

  logic                    in_xfer, out_xfer, fin_go;
  logic signed [DRV_W-1:0] sample_ext, drive;
  logic [NUM_W-1:0]        num;
  logic [DEN_W-1:0]        den;
  logic [COEF_BITS-1:0]    mul_a;
  logic [MB-1:0]           mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic [COEF_BITS:0]      one_minus_q;
  logic [DEN_W:0]          div_t;
  logic                    div_ge;
  logic [DEN_W-1:0]        rem_next;
  logic [COEF_BITS-1:0]    prod_hi, repro;
  logic signed [SUM_W-1:0] free_sum, cleft_sum, store_sum;
  logic [hcs_pkg::RATE_BITS-1:0] rate_sat;

  function automatic logic [COEF_BITS-1:0] clamp_store(input logic signed [SUM_W-1:0] v);
    logic [COEF_BITS-1:0] r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (|v[SUM_W-2:COEF_BITS]) begin
      r = '1;
    end else begin
      r = v[COEF_BITS-1:0];
    end
    return r;
  endfunction

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign fin_go   = (state_q == hcs_pkg::ST_FINISH) && (!out_valid_q || out_o.ready);

  assign in_i.ready        = (state_q == hcs_pkg::ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.firing_rate = rate_q;

  // drive = 10*s + A, zero when not positive
  assign sample_ext = DRV_W'(sample_q);
  assign drive      = (sample_ext <<< 3) + (sample_ext <<< 1) + DriveOfs;
  assign num        = (!drive[DRV_W-1] && (drive != '0)) ? drive[NUM_W-1:0] : '0;
  assign den        = DEN_W'(num) + DenOfs;

  // restoring division step, one quotient bit
  assign div_t    = {rem_q, lo_q[COEF_BITS-1]};
  assign div_ge   = (div_t >= {1'b0, den_q});
  assign rem_next = div_ge ? DEN_W'(div_t - {1'b0, den_q}) : div_t[DEN_W-1:0];

  assign one_minus_q = {1'b1, {COEF_BITS{1'b0}}} - {1'b0, free_q};

  // store products are below 2^(2*COEF_BITS)
  assign prod_hi = prod_q[2*COEF_BITS-1:COEF_BITS];
  assign repro   = prod_hi;

  assign free_sum  = SUM_W'(free_q) + SUM_W'(repl_q) - SUM_W'(eject_q) + SUM_W'(repro);
  assign cleft_sum = SUM_W'(cleft_q) + SUM_W'(eject_q) - SUM_W'(loss_q) - SUM_W'(reup_q);
  assign store_sum = SUM_W'(store_q) + SUM_W'(reup_q) - SUM_W'(repro);

  assign rate_sat = (|prod_q[PROD_W-1:RHI]) ? '1 : prod_q[RHI-1:RLO];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      hcs_pkg::ST_KMUL: begin
        mul_a = gain_q;
        mul_b = MB'(num);
      end
      hcs_pkg::ST_MEJECT: begin
        mul_a = lo_q;
        mul_b = MB'(free_q);
      end
      hcs_pkg::ST_MREPL: begin
        mul_a = repl_coef_q;
        mul_b = MB'(one_minus_q);
      end
      hcs_pkg::ST_MLOSS: begin
        mul_a = loss_coef_q;
        mul_b = MB'(cleft_q);
      end
      hcs_pkg::ST_MREUP: begin
        mul_a = ret_coef_q;
        mul_b = MB'(cleft_q);
      end
      hcs_pkg::ST_MREPRO: begin
        mul_a = repro_coef_q;
        mul_b = MB'(store_q);
      end
      hcs_pkg::ST_MRATE: begin
        mul_a = cleft_q;
        mul_b = RateH;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hcs_pkg::ST_IDLE:    if (in_xfer) state_d = hcs_pkg::ST_KMUL;
      hcs_pkg::ST_KMUL:    state_d = hcs_pkg::ST_DINIT;
      hcs_pkg::ST_DINIT:   state_d = hcs_pkg::ST_DIV;
      hcs_pkg::ST_DIV:     if (cnt_q == CntLast) state_d = hcs_pkg::ST_MEJECT;
      hcs_pkg::ST_MEJECT:  state_d = hcs_pkg::ST_MREPL;
      hcs_pkg::ST_MREPL:   state_d = hcs_pkg::ST_MLOSS;
      hcs_pkg::ST_MLOSS:   state_d = hcs_pkg::ST_MREUP;
      hcs_pkg::ST_MREUP:   state_d = hcs_pkg::ST_MREPRO;
      hcs_pkg::ST_MREPRO:  state_d = hcs_pkg::ST_UPDATE;
      hcs_pkg::ST_UPDATE:  state_d = hcs_pkg::ST_MRATE;
      hcs_pkg::ST_MRATE:   state_d = hcs_pkg::ST_FINISH;
      hcs_pkg::ST_FINISH:  if (fin_go) state_d = hcs_pkg::ST_IDLE;
      default:             state_d = hcs_pkg::ST_IDLE;
    endcase
  end

  // control, configuration and stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hcs_pkg::ST_IDLE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      gain_q       <= '0;
      repl_coef_q  <= '0;
      loss_coef_q  <= '0;
      ret_coef_q   <= '0;
      repro_coef_q <= '0;
      rest_free_q  <= '1;
      rest_cleft_q <= '0;
      rest_store_q <= '0;
      free_q       <= '0;
      cleft_q      <= '0;
      store_q      <= '0;
    end else begin
      state_q <= state_d;

      if (state_q == hcs_pkg::ST_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end

      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_i.valid && cfg_i.ready) begin
        unique case (hcs_pkg::cfg_reg_e'(cfg_i.index))
          hcs_pkg::CFG_GAIN:       gain_q       <= cfg_i.data;
          hcs_pkg::CFG_REPLENISH:  repl_coef_q  <= cfg_i.data;
          hcs_pkg::CFG_LOSS:       loss_coef_q  <= cfg_i.data;
          hcs_pkg::CFG_RETURN:     ret_coef_q   <= cfg_i.data;
          hcs_pkg::CFG_REPROCESS:  repro_coef_q <= cfg_i.data;
          hcs_pkg::CFG_REST_FREE:  rest_free_q  <= cfg_i.data;
          hcs_pkg::CFG_REST_CLEFT: rest_cleft_q <= cfg_i.data;
          hcs_pkg::CFG_REST_STORE: rest_store_q <= cfg_i.data;
          default: ;
        endcase
      end

      // reload resting values on a channel start
      if (in_xfer && in_i.first_of_channel) begin
        free_q  <= rest_free_q;
        cleft_q <= rest_cleft_q;
        store_q <= rest_store_q;
      end else if (state_q == hcs_pkg::ST_UPDATE) begin
        free_q  <= clamp_store(free_sum);
        cleft_q <= clamp_store(cleft_sum);
        store_q <= clamp_store(store_sum);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= in_i.membrane_sample;
    end

    // every multiply state registers the product, the next state picks it up;
    // the rate product is held while the finished result waits
    if (state_q != hcs_pkg::ST_FINISH) begin
      prod_q <= mul_p;
    end

    unique case (state_q)
      hcs_pkg::ST_KMUL: begin
        den_q <= den;
      end
      hcs_pkg::ST_DINIT: begin
        // quotient fits in COEF_BITS, so the high dividend part is below den
        rem_q <= DEN_W'(prod_q[COEF_BITS+NUM_W-1:COEF_BITS]);
        lo_q  <= prod_q[COEF_BITS-1:0];
      end
      hcs_pkg::ST_DIV: begin
        rem_q <= rem_next;
        lo_q  <= {lo_q[COEF_BITS-2:0], div_ge};
      end
      hcs_pkg::ST_MREPL:  eject_q <= prod_hi;
      hcs_pkg::ST_MLOSS:  repl_q  <= prod_hi;
      hcs_pkg::ST_MREUP:  loss_q  <= prod_hi;
      hcs_pkg::ST_MREPRO: reup_q  <= prod_hi;
      default: ;
    endcase

    if (fin_go) begin
      rate_q <= rate_sat;
    end
  end

endmodule

// ===== sv/hcs_checker.sv =====
module hcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [hcs_pkg::RATE_BITS-1:0] firing_rate_i
);

  logic       in_xfer, out_xfer;
  logic [1:0] pending_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // samples taken minus results delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // one sample at a time in the sequencer
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input taken again right after a transfer");

  // a result only appears at the end of a sample's work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while idle");

  // no result without a sample behind it
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pending_q != 2'd0))
    else $error("result with no pending sample");

  // at most one sample in work and one result waiting
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (pending_q == 2'd0 || pending_q == 2'd1))
    else $error("too many samples in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(firing_rate_i))
    else $error("stalled result changed");

endmodule

bind hair_cell_synapse_model_core hcs_checker u_hcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .firing_rate_i(out_o.firing_rate)
);

// ===== bench/tb.sv =====
module tb;

  // widths of the block under test
  localparam int unsigned SB = hcs_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned CB = hcs_pkg::COEF_BITS_DEF;
  localparam int unsigned RB = hcs_pkg::RATE_BITS;

  // fixed-point limits of the stores and of the firing rate
  localparam longint STORE_MAX = (longint'(1) << CB) - 1;
  localparam longint RATE_MAX  = (longint'(1) << RB) - 1;

  // drive = 10*s + A, with A and B scaled to the sample format
  localparam longint DRIVE_SCALE = 10;

  // cycles waited at the end of the run, after the last drain
  localparam int unsigned SAMPLE_CYCLES = CB + 11;

  localparam int unsigned RANDOM_ITEMS = 1150;
  // cycles without any transfer before the run is called hung
  localparam int unsigned STALL_LIMIT  = 4000;

  // one row of the directed part: a register write or a sample; a sample row
  // may carry a firing rate that is obvious by inspection
  typedef struct packed {
    logic                   wr;
    hcs_pkg::cfg_reg_e      idx;
    logic [CB-1:0]          val;
    logic signed [SB-1:0]   smp;
    logic                   reload;
    logic                   known;
    logic [RB-1:0]          rate;
  } plan_row_t;

  localparam int unsigned PLAN_LEN = 35;

  // firing rate of a full cleft: floor(50000 * (2^24-1) / 2^16)
  localparam logic [RB-1:0] FULL_CLEFT_RATE = 24'd12799999;

  plan_row_t plan [0:PLAN_LEN-1] = '{
    // straight out of reset every coefficient is zero and the stores are empty
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          0,      1'b0, 1'b1, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          32767,  1'b0, 1'b1, 0},
    // reload with the reset resting values: cleft still empty
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          -32768, 1'b1, 1'b1, 0},
    // full cleft with no loss and no reuptake stays full, rate at its top
    '{1'b1, hcs_pkg::CFG_REST_CLEFT, 24'hFFFFFF, 0,      1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          0,      1'b1, 1'b1, FULL_CLEFT_RATE},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          -16384, 1'b0, 1'b1, FULL_CLEFT_RATE},
    // a plausible operating point, full gain
    '{1'b1, hcs_pkg::CFG_GAIN,       24'hFFFFFF, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_REPLENISH,  24'h001000, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_LOSS,       24'h0A0000, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_RETURN,     24'h060000, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_REPROCESS,  24'h004000, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_REST_FREE,  24'h800000, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_REST_CLEFT, 24'h000000, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_REST_STORE, 24'h400000, 0,      1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          32767,  1'b1, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          32767,  1'b0, 1'b0, 0},
    // most negative sample: negative drive, no permeability
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          -32768, 1'b0, 1'b0, 0},
    // drive exactly zero, then the smallest positive drive
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          -16384, 1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          -16383, 1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          1,      1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          -1,     1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          21845,  1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          -21846, 1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          0,      1'b1, 1'b0, 0},
    // every coefficient and resting value at full scale: cleft saturates low,
    // free transmitter saturates high
    '{1'b1, hcs_pkg::CFG_REPLENISH,  24'hFFFFFF, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_LOSS,       24'hFFFFFF, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_RETURN,     24'hFFFFFF, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_REPROCESS,  24'hFFFFFF, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_REST_FREE,  24'hFFFFFF, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_REST_CLEFT, 24'hFFFFFF, 0,      1'b0, 1'b0, 0},
    '{1'b1, hcs_pkg::CFG_REST_STORE, 24'hFFFFFF, 0,      1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          32767,  1'b1, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          32767,  1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          -32768, 1'b0, 1'b0, 0},
    '{1'b0, hcs_pkg::CFG_GAIN,       0,          0,      1'b0, 1'b0, 0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hcs_in_if  #(.SAMPLE_BITS(SB)) in_if ();
  hcs_out_if                     out_if ();
  hcs_cfg_if #(.COEF_BITS(CB))   cfg_if ();

  hair_cell_synapse_model_core #(
    .SAMPLE_BITS(SB),
    .COEF_BITS  (CB)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_i (in_if),
    .out_o(out_if),
    .cfg_i(cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // synapse shadow: register file and the three transmitter stores
  logic [CB-1:0]        coef_r [8];
  logic [CB-1:0]        avail_tx, cleft_tx, reproc_tx;
  // firing rates still owed by the block, oldest first
  logic [RB-1:0]        rate_q [$];
  logic [RB-1:0]        want_rate;

  int unsigned mismatch_cnt = 0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_cnt     = 0;
  int unsigned hold_mode    = 0;

  function automatic void shadow_reset();
    for (int r = 0; r < 8; r++) begin
      coef_r[r] = '0;
    end
    coef_r[hcs_pkg::CFG_REST_FREE] = '1;
    avail_tx  = '0;
    cleft_tx  = '0;
    reproc_tx = '0;
  endfunction

  function automatic logic [CB-1:0] clip_store(longint v);
    if (v < 0) return '0;
    if (v > STORE_MAX) return '1;
    return v[CB-1:0];
  endfunction

  // one synapse update: permeability from the sample, then the transmitter
  // flows between the stores; returns the firing rate of the new cleft
  function automatic logic [RB-1:0] synapse_step(logic signed [SB-1:0] smp,
                                                logic reload);
    longint drive, perm, q, c, w, repl, eject, loss, reup, repro, rate;
    if (reload) begin
      avail_tx  = coef_r[hcs_pkg::CFG_REST_FREE];
      cleft_tx  = coef_r[hcs_pkg::CFG_REST_CLEFT];
      reproc_tx = coef_r[hcs_pkg::CFG_REST_STORE];
    end
    q = longint'(avail_tx);
    c = longint'(cleft_tx);
    w = longint'(reproc_tx);

    // no permeability unless 10x+5 is positive
    drive = DRIVE_SCALE * longint'(smp) + (longint'(hcs_pkg::DRIVE_A) << (SB - 1));
    perm  = 0;
    if (drive > 0) begin
      perm = (longint'(coef_r[hcs_pkg::CFG_GAIN]) * drive) /
             (drive + (longint'(hcs_pkg::DRIVE_B) << (SB - 1)));
    end

    // all products floor; replenishment uses M = 1 as the full store
    repl  = (longint'(coef_r[hcs_pkg::CFG_REPLENISH]) * ((longint'(1) << CB) - q)) >> CB;
    eject = (perm * q) >> CB;
    loss  = (longint'(coef_r[hcs_pkg::CFG_LOSS]) * c) >> CB;
    reup  = (longint'(coef_r[hcs_pkg::CFG_RETURN]) * c) >> CB;
    repro = (longint'(coef_r[hcs_pkg::CFG_REPROCESS]) * w) >> CB;

    avail_tx  = clip_store(q + repl - eject + repro);
    cleft_tx  = clip_store(c + eject - loss - reup);
    reproc_tx = clip_store(w + reup - repro);

    rate = (longint'(hcs_pkg::RATE_H) * longint'(cleft_tx)) >> (CB - hcs_pkg::RATE_FRAC_BITS);
    if (rate > RATE_MAX) rate = RATE_MAX;
    return rate[RB-1:0];
  endfunction

  function automatic logic [CB-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      // small factors, the range a real cochlear channel lives in
      2, 3, 4: return CB'($urandom_range(0, 1 << 16));
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    logic signed [SB-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        // corners: both ends of the range, zero drive and just above it
        case ($urandom_range(0, 4))
          0: v = {1'b1, {(SB-1){1'b0}}};
          1: v = {1'b0, {(SB-1){1'b1}}};
          2: v = SB'(-(1 <<< (SB - 2)));
          3: v = SB'(-(1 <<< (SB - 2)) + 1);
          default: v = '0;
        endcase
      end
      1, 2, 3: v = SB'($signed($urandom_range(0, 6000)) - 3000);
      default: v = SB'($urandom);
    endcase
    return v;
  endfunction

  // sender bursts: after a burst runs out, drop valid for a random gap
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // one sample transfer; the rate it owes is queued at acceptance
  task automatic send_sample(logic signed [SB-1:0] smp, logic reload,
                             logic known, logic [RB-1:0] known_rate);
    logic [RB-1:0] predicted;
    in_if.valid            <= 1'b1;
    in_if.membrane_sample  <= smp;
    in_if.first_of_channel <= reload;
    cfg_if.valid           <= 1'b0;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = synapse_step(smp, reload);
    rate_q.push_back(known ? known_rate : predicted);
    items_sent++;
    pace();
  endtask

  // hold off until every owed rate has come back; the block is then idle
  task automatic drain();
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    do @(posedge clk_i); while (rate_q.size() != 0);
  endtask

  task automatic cfg_write(hcs_pkg::cfg_reg_e idx, logic [CB-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    coef_r[idx] = val;
  endtask

  // new register setting between phases: every so often all at full scale
  // or all cleared, otherwise a random subset rewritten
  task automatic retune(int unsigned phase_no);
    logic [CB-1:0] val;
    for (int r = 0; r < 8; r++) begin
      if (phase_no % 6 == 0) val = '1;
      else if (phase_no % 6 == 3) val = '0;
      else if ($urandom_range(0, 2) == 0) continue;
      else val = pick_coef();
      drain();
      cfg_write(hcs_pkg::cfg_reg_e'(r), val);
    end
  endtask

  // receiver: a stall mode held for a random stretch of cycles
  always @(posedge clk_i) begin
    if (hold_cnt == 0) begin
      hold_mode <= $urandom_range(0, 3);
      hold_cnt  <= $urandom_range(20, 200);
    end else begin
      hold_cnt <= hold_cnt - 1;
    end
    case (hold_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= ($urandom_range(0, 7) == 0);
      default: out_if.ready <= hold_cnt[4];
    endcase
  end

  // result check against the oldest owed rate
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rate_q.size() == 0) begin
        $display("%0t: firing rate transfer with none owed, expected none, actual %0d",
                 $time, out_if.firing_rate);
        mismatch_cnt++;
      end else begin
        want_rate = rate_q.pop_front();
        if (out_if.firing_rate !== want_rate) begin
          $display("%0t: firing_rate mismatch, expected %0d, actual %0d",
                   $time, want_rate, out_if.firing_rate);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d rates still owed",
               $time, quiet_cycles, rate_q.size());
      $display("[hair_cell_synapse_model_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_no;
    int unsigned seq_len;
    logic        broken;
    logic        reload;

    in_if.valid            <= 1'b0;
    in_if.membrane_sample  <= '0;
    in_if.first_of_channel <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= hcs_pkg::CFG_GAIN;
    cfg_if.data            <= '0;
    shadow_reset();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part; register rows wait for the block to go idle
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].wr) begin
        drain();
        cfg_write(plan[i].idx, plan[i].val);
      end else begin
        send_sample(plan[i].smp, plan[i].reload, plan[i].known, plan[i].rate);
      end
    end

    // random part: phases of channel sequences, each normally opened by a
    // reload; some sequences lack the opening flag and a few flags are noise
    items_sent = 0;
    phase_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      retune(phase_no);
      repeat ($urandom_range(1, 4)) begin
        // pressure: let everything drain before the next sequence starts
        if ($urandom_range(0, 11) == 0) drain();
        seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4)
                                              : $urandom_range(10, 60);
        broken  = ($urandom_range(0, 9) == 0);
        for (int j = 0; j < seq_len && items_sent < RANDOM_ITEMS; j++) begin
          reload = (j == 0) && !broken;
          if ($urandom_range(0, 19) == 0) reload = $urandom_range(0, 1);
          send_sample(pick_sample(), reload, 1'b0, '0);
        end
      end
      phase_no++;
    end

    drain();
    repeat (SAMPLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[hair_cell_synapse_model_core] OK");
    end else begin
      $display("[hair_cell_synapse_model_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/hcs_pkg.sv
sv/hcs_if.sv
sv/hair_cell_synapse_model_core.sv
sv/hcs_checker.sv
bench/tb.sv
